/* rtl/cfir3_pkg.sv */
`timescale 1ns / 1ps

package cfir3_pkg;

	// Default sizes, handed to the top level parameters
	localparam int TAPS_DEF        = 77;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_BITS_DEF   = 18;

	// Kernel description: symmetric, values in units of 1e-7
	localparam int KERNEL_LEN = 77;
	localparam int KERNEL_MID = 38;
	localparam longint DEC_SCALE = 64'd10000000;

	localparam int KERNEL_DEC [KERNEL_MID+1] = '{
		-537, 931, 0, -2125, 2975, 0, -5323, 6884, 0, -10961,
		13556, 0, -20089, 24126, 0, -34034, 40038, 0, -54548, 63249,
		0, -84171, 96722, 0, -127151, 145691, 0, -191968, 221333, 0,
		-299666, 353963, 0, -522236, 665693, 0, -1366458, 2750696, 6666667
	};

	// Coefficient k in Q1.(coef_bits-1), rounded half away from zero.
	// Taps past the kernel length are zero.
	function automatic longint coef_val(input int k, input int coef_bits);
		int idx;
		longint d;
		longint mag;
		longint q;
		if (k >= KERNEL_LEN) begin
			return 64'sd0;
		end
		idx = (k <= KERNEL_MID) ? k : (KERNEL_LEN - 1 - k);
		d = longint'(KERNEL_DEC[idx]);
		mag = (d < 0) ? -d : d;
		q = ((mag <<< (coef_bits - 1)) + DEC_SCALE / 2) / DEC_SCALE;
		return (d < 0) ? -q : q;
	endfunction

endpackage

/* rtl/cfir3_cell.sv */
`timescale 1ns / 1ps

// One tap of the transposed-form filter: multiplies the new sample by its
// fixed coefficient and adds the partial sum handed over by its neighbor.
module cfir3_cell #(
	parameter int SAMPLE_BITS = cfir3_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = cfir3_pkg::COEF_BITS_DEF,
	parameter int ACC_BITS    = 41,
	parameter logic signed [COEF_BITS-1:0] COEF = '0
) (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic signed [SAMPLE_BITS-1:0] x_re,
	input  logic signed [SAMPLE_BITS-1:0] x_im,
	input  logic signed [ACC_BITS-1:0]    sum_in_re,
	input  logic signed [ACC_BITS-1:0]    sum_in_im,
	output logic signed [ACC_BITS-1:0]    sum_re_q,
	output logic signed [ACC_BITS-1:0]    sum_im_q
);
	import cfir3_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;

	logic signed [PROD_BITS-1:0] prod_re;
	logic signed [PROD_BITS-1:0] prod_im;

	// Products at full precision
	assign prod_re = x_re * COEF;
	assign prod_im = x_im * COEF;

	// Partial sums advance one cell toward the output on every transfer
	always_ff @(posedge clk) begin
		if (shift_en) begin
			sum_re_q <= ACC_BITS'(prod_re) + sum_in_re;
			sum_im_q <= ACC_BITS'(prod_im) + sum_in_im;
		end
	end

endmodule

/* rtl/cfir3_round.sv */
`timescale 1ns / 1ps

// Output register: rounds the full sum to the sample format, ties toward
// plus infinity, and saturates.
module cfir3_round #(
	parameter int SAMPLE_BITS = cfir3_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = cfir3_pkg::COEF_BITS_DEF,
	parameter int ACC_BITS    = 41
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic signed [ACC_BITS-1:0]    sum_re,
	input  logic signed [ACC_BITS-1:0]    sum_im,
	output logic signed [SAMPLE_BITS-1:0] res_re_q,
	output logic signed [SAMPLE_BITS-1:0] res_im_q
);
	import cfir3_pkg::*;

	localparam int SH = COEF_BITS - 1;
	localparam int RW = ACC_BITS + 1 - SH;

	localparam logic signed [RW-1:0] MAX_V = RW'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RW-1:0] MIN_V = RW'(-(longint'(1) <<< (SAMPLE_BITS - 1)));
	localparam logic signed [ACC_BITS:0] HALF = (ACC_BITS+1)'(longint'(1) <<< (SH - 1));

	logic signed [ACC_BITS:0]      biased_re;
	logic signed [ACC_BITS:0]      biased_im;
	logic signed [RW-1:0]          r_re;
	logic signed [RW-1:0]          r_im;
	logic signed [SAMPLE_BITS-1:0] sat_re;
	logic signed [SAMPLE_BITS-1:0] sat_im;

	// Add half an LSB, then drop the fraction bits (floor)
	always_comb begin
		biased_re = {sum_re[ACC_BITS-1], sum_re} + HALF;
		biased_im = {sum_im[ACC_BITS-1], sum_im} + HALF;
		r_re = biased_re[ACC_BITS:SH];
		r_im = biased_im[ACC_BITS:SH];
	end

	// Clamp to the sample range
	always_comb begin
		if (r_re > MAX_V) begin
			sat_re = MAX_V[SAMPLE_BITS-1:0];
		end else if (r_re < MIN_V) begin
			sat_re = MIN_V[SAMPLE_BITS-1:0];
		end else begin
			sat_re = r_re[SAMPLE_BITS-1:0];
		end
		if (r_im > MAX_V) begin
			sat_im = MAX_V[SAMPLE_BITS-1:0];
		end else if (r_im < MIN_V) begin
			sat_im = MIN_V[SAMPLE_BITS-1:0];
		end else begin
			sat_im = r_im[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_re_q <= sat_re;
			res_im_q <= sat_im;
		end
	end

endmodule

/* rtl/complex_fir_third_band.sv */
`timescale 1ns / 1ps

// Channel | Handshake           | Payload
// --------+---------------------+--------------------------------
// in      | in_valid / in_stall  | sample_re, sample_im (Q1.15)
// out     | out_valid / out_stall| filtered_re, filtered_im (Q1.15)
//
// One input transfer per cycle sustained while the output drains; the row of
// TAPS cells advances only on an input transfer, the first TAPS-1 give no result.
// out_valid rises once a completed window's sum has moved on: the completing
// transfer lands it in cell 0, from which it loads into the round/saturate register.
// Reset (arst_n low) clears the fill counter and the valid flags.
// in_stall rises only while a finished sum waits in cell 0 behind a stalled output.
module complex_fir_third_band #(
	parameter int TAPS        = cfir3_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = cfir3_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = cfir3_pkg::COEF_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_re,
	input  logic signed [SAMPLE_BITS-1:0] sample_im,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered_re,
	output logic signed [SAMPLE_BITS-1:0] filtered_im
);
	import cfir3_pkg::*;

	localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + $clog2(TAPS);
	localparam int CNT_W    = $clog2(TAPS);
	localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(TAPS - 1);

	logic                       in_xfer;
	logic                       move;
	logic                       sum_valid_q;
	logic                       out_valid_q;
	logic [CNT_W-1:0]           fill_q;
	logic signed [ACC_BITS-1:0] sum_re [TAPS+1];
	logic signed [ACC_BITS-1:0] sum_im [TAPS+1];

	// Handshake: the row may shift unless a finished sum is stuck in cell 0
	assign move     = sum_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = sum_valid_q && out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	// Far end of the row feeds zero
	assign sum_re[TAPS] = '0;
	assign sum_im[TAPS] = '0;

	// Cell k weights the newest sample by coefficient TAPS-1-k
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		localparam longint CV = coef_val(TAPS - 1 - k, COEF_BITS);
		cfir3_cell #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.COEF_BITS  (COEF_BITS),
			.ACC_BITS   (ACC_BITS),
			.COEF       (CV[COEF_BITS-1:0])
		) u_cell (
			.clk      (clk),
			.shift_en (in_xfer),
			.x_re     (sample_re),
			.x_im     (sample_im),
			.sum_in_re(sum_re[k+1]),
			.sum_in_im(sum_im[k+1]),
			.sum_re_q (sum_re[k]),
			.sum_im_q (sum_im[k])
		);
	end

	cfir3_round #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.ACC_BITS   (ACC_BITS)
	) u_round (
		.clk     (clk),
		.load    (move),
		.sum_re  (sum_re[0]),
		.sum_im  (sum_im[0]),
		.res_re_q(filtered_re),
		.res_im_q(filtered_im)
	);

	// Fill counter and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			sum_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				sum_valid_q <= (fill_q == FILL_LAST);
				if (fill_q != FILL_LAST) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (move) begin
				sum_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A sum moved to the output register shows as valid next cycle
	a_move_out: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid_q)
		else $error("result lost between last cell and output register");

	// No finished sum before the window is full
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid_q |-> (fill_q == FILL_LAST))
		else $error("sum flagged valid during fill");

	// The row never shifts while a finished sum is held
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_valid_q && !move) |-> !in_xfer)
		else $error("held sum overwritten by an input transfer");

	// A held output stays put and the pending sum stays pending
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && sum_valid_q) |=> (out_valid_q && sum_valid_q))
		else $error("stalled result dropped");

endmodule

/* sim/cfir3_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the complex FIR, predicts every filtered sample
// from the accepted input samples and compares each output transfer against
// the oldest prediction still waiting.
module cfir3_checker (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	input  logic                                       in_stall,
	input  logic signed [cfir3_pkg::SAMPLE_BITS_DEF-1:0] sample_re,
	input  logic signed [cfir3_pkg::SAMPLE_BITS_DEF-1:0] sample_im,
	input  logic                                       out_valid,
	input  logic                                       out_stall,
	input  logic signed [cfir3_pkg::SAMPLE_BITS_DEF-1:0] filtered_re,
	input  logic signed [cfir3_pkg::SAMPLE_BITS_DEF-1:0] filtered_im,
	output int                                         outstanding,
	output int                                         mismatches
);

	localparam int TAPS = cfir3_pkg::TAPS_DEF;
	localparam int SB   = cfir3_pkg::SAMPLE_BITS_DEF;
	localparam int CB   = cfir3_pkg::COEF_BITS_DEF;

	localparam int KLEN = 77;
	localparam int KMID = 38;
	localparam longint DEC_UNIT = 64'sd10000000;

	localparam longint OUT_MAX = (64'sd1 <<< (SB - 1)) - 1;
	localparam longint OUT_MIN = -(64'sd1 <<< (SB - 1));

	// low-pass kernel up to the centre tap, in units of 1e-7
	localparam int HALF_KERNEL [KMID+1] = '{
		-537, 931, 0, -2125, 2975, 0, -5323, 6884, 0, -10961,
		13556, 0, -20089, 24126, 0, -34034, 40038, 0, -54548, 63249,
		0, -84171, 96722, 0, -127151, 145691, 0, -191968, 221333, 0,
		-299666, 353963, 0, -522236, 665693, 0, -1366458, 2750696, 6666667
	};

	typedef struct packed {
		logic signed [SB-1:0] re;
		logic signed [SB-1:0] im;
	} cplx_t;

	longint tap_coef [TAPS];
	logic signed [SB-1:0] window_re [TAPS];
	logic signed [SB-1:0] window_im [TAPS];
	int     primed;
	cplx_t  due_results [$];
	int     errors;
	int     checked;

	// Coefficients in Q1.(CB-1), rounded half away from zero
	initial begin
		int     d;
		longint mag;
		longint q;
		for (int k = 0; k < TAPS; k++) begin
			if (k >= KLEN) begin
				tap_coef[k] = 0;
			end else begin
				d = (k <= KMID) ? HALF_KERNEL[k] : HALF_KERNEL[KLEN - 1 - k];
				mag = (d < 0) ? -longint'(d) : longint'(d);
				q = ((mag <<< (CB - 1)) + DEC_UNIT / 2) / DEC_UNIT;
				tap_coef[k] = (d < 0) ? -q : q;
			end
		end
	end

	// Drop CB-1 fraction bits, ties toward plus infinity, then clip
	function automatic logic signed [SB-1:0] round_clip(input longint acc);
		longint r;
		r = (acc + (64'sd1 <<< (CB - 2))) >>> (CB - 1);
		if (r > OUT_MAX) r = OUT_MAX;
		if (r < OUT_MIN) r = OUT_MIN;
		return r[SB-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: %s", $time, msg);
	endtask

	// Shift one sample into the window; once full, queue the filtered pair
	task automatic shift_in_sample(input logic signed [SB-1:0] re,
			input logic signed [SB-1:0] im);
		longint acc_re;
		longint acc_im;
		cplx_t  res;
		for (int k = 0; k < TAPS - 1; k++) begin
			window_re[k] = window_re[k+1];
			window_im[k] = window_im[k+1];
		end
		window_re[TAPS-1] = re;
		window_im[TAPS-1] = im;
		if (primed < TAPS - 1) begin
			primed++;
			return;
		end
		acc_re = 0;
		acc_im = 0;
		for (int k = 0; k < TAPS; k++) begin
			acc_re += longint'(window_re[k]) * tap_coef[k];
			acc_im += longint'(window_im[k]) * tap_coef[k];
		end
		res.re = round_clip(acc_re);
		res.im = round_clip(acc_im);
		due_results.push_back(res);
	endtask

	// Output transfers are checked before the input transfer of the same edge
	always @(posedge clk or negedge arst_n) begin
		cplx_t want;
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				window_re[k] = '0;
				window_im[k] = '0;
			end
			primed = 0;
			errors = 0;
			checked = 0;
			due_results.delete();
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result re %0d im %0d",
						filtered_re, filtered_im));
				end else begin
					want = due_results.pop_front();
					if (filtered_re !== want.re)
						report_mismatch($sformatf("result %0d: filtered_re %0d, want %0d",
							checked, filtered_re, want.re));
					if (filtered_im !== want.im)
						report_mismatch($sformatf("result %0d: filtered_im %0d, want %0d",
							checked, filtered_im, want.im));
				end
				checked++;
			end
			if (in_valid && !in_stall)
				shift_in_sample(sample_re, sample_im);
			outstanding <= due_results.size();
			mismatches <= errors;
		end
	end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int TAPS = cfir3_pkg::TAPS_DEF;
	localparam int SB   = cfir3_pkg::SAMPLE_BITS_DEF;
	localparam int KMID = 38;
	localparam int RANDOM_ITEMS = 2000;

	localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

	// kinds of sample runs in the random part
	typedef enum int {
		RUN_NOISE,
		RUN_CLIP,
		RUN_IMPULSE,
		RUN_DC,
		RUN_FAINT
	} run_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [SB-1:0] sample_re;
	logic signed [SB-1:0] sample_im;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [SB-1:0] filtered_re;
	logic signed [SB-1:0] filtered_im;
	int                   outstanding;
	int                   mismatches;
	int                   sent;

	complex_fir_third_band dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_re   (sample_re),
		.sample_im   (sample_im),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.filtered_re (filtered_re),
		.filtered_im (filtered_im)
	);

	cfir3_checker filter_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_re   (sample_re),
		.sample_im   (sample_im),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.filtered_re (filtered_re),
		.filtered_im (filtered_im),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	// Offer one sample after a random gap and hold it until the transfer
	task automatic offer_sample(input logic signed [SB-1:0] re,
			input logic signed [SB-1:0] im);
		int gap;
		// once: let the pipeline run dry before going on
		if (sent == 1500) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (outstanding != 0);
		end
		gap = (sent >= 600 && sent < 800) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_re <= re;
		sample_im <= im;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// Result side: random stall before each transfer, one quiet stretch,
	// and one long hold-off that backs the filter up to its input
	initial begin
		int hold;
		int taken;
		taken = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (taken == 1000)
				hold = 400;
			else if (taken >= 300 && taken < 500)
				hold = 0;
			else
				hold = $urandom_range(0, 7);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Stimulus and verdict
	initial begin
		run_kind_t            kind;
		int                   len;
		int                   runs;
		int                   m;
		int                   sgn;
		bit                   pos_re;
		bit                   pos_im;
		logic signed [SB-1:0] v_re;
		logic signed [SB-1:0] v_im;

		sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample_re <= '0;
		sample_im <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// field extremes and bit patterns, the first samples into the delay line
		offer_sample(S_MAX, S_MIN);
		offer_sample(S_MIN, S_MAX);
		offer_sample('0, '0);
		offer_sample(SB'(-1), SB'(1));
		offer_sample(SB'(1), SB'(-1));
		offer_sample(SB'('h5555), SB'('hAAAA));
		offer_sample(SB'('hAAAA), SB'('h5555));
		offer_sample(S_MAX, S_MAX);
		offer_sample(S_MIN, S_MIN);
		offer_sample('0, S_MAX);
		offer_sample(S_MIN, '0);
		offer_sample(SB'('h00FF), SB'('hFF00));

		runs = 0;
		while (sent < 12 + RANDOM_ITEMS) begin
			kind = (runs < 2) ? RUN_CLIP : run_kind_t'($urandom_range(0, 4));
			runs++;
			case (kind)
				RUN_NOISE: begin
					len = $urandom_range(1, 40);
					repeat (len) offer_sample(SB'($urandom), SB'($urandom));
				end
				// a window that matches the kernel signs drives the output
				// into saturation, toward either limit
				RUN_CLIP: begin
					pos_re = 1'($urandom_range(0, 1));
					pos_im = 1'($urandom_range(0, 1));
					for (int j = 0; j < TAPS; j++) begin
						m = (j <= KMID) ? j : TAPS - 1 - j;
						sgn = (m == KMID) ? 1 : (m % 3 == 0) ? -1 : (m % 3 == 1) ? 1 : 0;
						if (sgn == 0) begin
							v_re = SB'($urandom);
							v_im = SB'($urandom);
						end else begin
							v_re = ((sgn > 0) == pos_re) ? S_MAX : S_MIN;
							v_im = ((sgn > 0) == pos_im) ? S_MAX : S_MIN;
						end
						offer_sample(v_re, v_im);
					end
				end
				RUN_IMPULSE: begin
					offer_sample($urandom_range(0, 1) ? S_MAX : S_MIN,
						$urandom_range(0, 1) ? S_MAX : S_MIN);
					len = $urandom_range(10, 80);
					repeat (len) offer_sample('0, '0);
				end
				RUN_DC: begin
					v_re = SB'($urandom);
					v_im = SB'($urandom);
					len = $urandom_range(10, 100);
					repeat (len) offer_sample(v_re, v_im);
				end
				default: begin
					// tiny values stress the rounding of the sum
					len = $urandom_range(1, 60);
					repeat (len) offer_sample(SB'($urandom_range(0, 15) - 8),
						SB'($urandom_range(0, 15) - 8));
				end
			endcase
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
